// ----- rtl/hsv_to_argb_colormap_macros.svh -----
// Assertion macros for the HSV-to-ARGB colormap block.
// Used by the top level only; expects clk and rst_n in scope.
`ifndef HSV_TO_ARGB_COLORMAP_MACROS_SVH
`define HSV_TO_ARGB_COLORMAP_MACROS_SVH

// Implication checked while out of reset.
`define HSVC_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Past cause, with reset high over the whole span since, implies effect now.
`define HSVC_ASSERT_LAT4(lbl, cause, effect, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) \
    ($past(rst_n, 1) && $past(rst_n, 2) && $past(rst_n, 3) && $past(rst_n, 4) && \
     $past(cause, 4)) |-> (effect)) \
    else $error(msg);

`endif

// ----- rtl/hsvc_pkg.sv -----
// Shared constants, stage types and byte scaling for the HSV-to-ARGB block.
// No dependencies.
package hsvc_pkg;

  localparam int FRAC_BITS = 16;
  localparam int QW        = FRAC_BITS + 1;

  localparam logic [QW-1:0]        ONE_Q       = {1'b1, {FRAC_BITS{1'b0}}};
  localparam logic [FRAC_BITS-1:0] FIVE_SIXTHS =
    FRAC_BITS'(((64'(1) << FRAC_BITS) * 5) / 6);

  typedef enum logic [2:0] {
    SEC_RED_UP   = 3'd0,
    SEC_GRN_FULL = 3'd1,
    SEC_BLU_UP   = 3'd2,
    SEC_BLU_FULL = 3'd3,
    SEC_RED_RISE = 3'd4,
    SEC_RED_FULL = 3'd5
  } sector_t;

  typedef logic [QW-1:0] q_t;

  typedef struct packed {
    logic                 valid;
    sector_t              sector;
    logic [FRAC_BITS-1:0] frac;
    q_t                   sat;
    q_t                   val;
    logic [7:0]           abyte;
  } stg1_t;

  typedef struct packed {
    logic       valid;
    sector_t    sector;
    q_t         wgt;
    q_t         chroma;
    q_t         val;
    logic [7:0] abyte;
  } stg2_t;

  typedef struct packed {
    logic       valid;
    sector_t    sector;
    q_t         xterm;
    q_t         offs;
    q_t         val;
    logic [7:0] abyte;
  } stg3_t;

  function automatic logic [7:0] to_byte(input q_t q);
    logic [QW+7:0] prod;
    prod = {q, 8'b0} - {8'b0, q};
    return prod[FRAC_BITS+7:FRAC_BITS];
  endfunction

endpackage

// ----- rtl/hsvc_front.sv -----
// Input stage: clamps operands, derives colormap HSV, splits hue into sector.
// Depends on hsvc_pkg.
module hsvc_front
  import hsvc_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 accept,
  input  logic                 in_mode,
  input  logic [FRAC_BITS-1:0] in_hue,
  input  logic [QW-1:0]        in_saturation,
  input  logic [QW-1:0]        in_brightness,
  input  logic [QW-1:0]        in_alpha,
  input  logic [QW-1:0]        in_level,
  output stg1_t                stg1
);

  stg1_t                stg1_r, stg1_nxt;
  q_t                   sat_c, val_c, alpha_c, lvl_c, map_sat, map_val;
  logic [QW:0]          two_n;
  logic                 over_half;
  logic [FRAC_BITS-1:0] hue_sel;
  logic [FRAC_BITS+2:0] h6;

  always_comb begin
    sat_c   = (in_saturation > ONE_Q) ? ONE_Q : in_saturation;
    val_c   = (in_brightness > ONE_Q) ? ONE_Q : in_brightness;
    alpha_c = (in_alpha > ONE_Q) ? ONE_Q : in_alpha;
    lvl_c   = (in_level > ONE_Q) ? ONE_Q : in_level;

    two_n     = {lvl_c, 1'b0};
    over_half = two_n > {1'b0, ONE_Q};
    map_sat   = over_half ? ONE_Q : two_n[QW-1:0];
    map_val   = over_half ? QW'({ONE_Q, 1'b0} - two_n) : ONE_Q;

    hue_sel = in_mode ? (FIVE_SIXTHS - lvl_c[FRAC_BITS-1:0]) : in_hue;
    h6      = ({3'b0, hue_sel} << 2) + ({3'b0, hue_sel} << 1);

    stg1_nxt.valid  = accept;
    stg1_nxt.sector = sector_t'(h6[FRAC_BITS+2:FRAC_BITS]);
    stg1_nxt.frac   = h6[FRAC_BITS-1:0];
    stg1_nxt.sat    = in_mode ? map_sat : sat_c;
    stg1_nxt.val    = in_mode ? map_val : val_c;
    stg1_nxt.abyte  = in_mode ? 8'd0 : to_byte(alpha_c);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg1_r <= '0;
    end else begin
      stg1_r <= stg1_nxt;
    end
  end

  assign stg1 = stg1_r;

endmodule

// ----- rtl/hsvc_mult.sv -----
// Two multiply stages: chroma = s*v, then secondary term = chroma*weight.
// Depends on hsvc_pkg.
module hsvc_mult
  import hsvc_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  stg1_t stg1,
  output stg3_t stg3
);

  stg2_t          stg2_r, stg2_nxt;
  stg3_t          stg3_r, stg3_nxt;
  logic [2*QW-1:0] c_full, x_full;
  q_t              frac_q;

  always_comb begin
    c_full = stg1.sat * stg1.val;
    frac_q = {1'b0, stg1.frac};

    stg2_nxt.valid  = stg1.valid;
    stg2_nxt.sector = stg1.sector;
    stg2_nxt.wgt    = stg1.sector[0] ? (ONE_Q - frac_q) : frac_q;
    stg2_nxt.chroma = c_full[FRAC_BITS+QW-1:FRAC_BITS];
    stg2_nxt.val    = stg1.val;
    stg2_nxt.abyte  = stg1.abyte;
  end

  always_comb begin
    x_full = stg2_r.chroma * stg2_r.wgt;

    stg3_nxt.valid  = stg2_r.valid;
    stg3_nxt.sector = stg2_r.sector;
    stg3_nxt.xterm  = x_full[FRAC_BITS+QW-1:FRAC_BITS];
    stg3_nxt.offs   = stg2_r.val - stg2_r.chroma;
    stg3_nxt.val    = stg2_r.val;
    stg3_nxt.abyte  = stg2_r.abyte;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg2_r <= '0;
      stg3_r <= '0;
    end else begin
      stg2_r <= stg2_nxt;
      stg3_r <= stg3_nxt;
    end
  end

  assign stg3 = stg3_r;

endmodule

// ----- rtl/hsvc_pack.sv -----
// Output stage: scales channels to bytes, orders them by sector, packs ARGB.
// Depends on hsvc_pkg.
module hsvc_pack
  import hsvc_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  stg3_t       stg3,
  output logic        out_valid,
  output logic [31:0] out_pixel
);

  logic        out_valid_r;
  logic [31:0] out_pixel_r, out_pixel_nxt;
  logic [7:0]  hi, mid, lo, r, g, b;

  always_comb begin
    hi  = to_byte(stg3.val);
    mid = to_byte(stg3.offs + stg3.xterm);
    lo  = to_byte(stg3.offs);
    unique case (stg3.sector)
      SEC_RED_UP: begin
        r = hi;  g = mid; b = lo;
      end
      SEC_GRN_FULL: begin
        r = mid; g = hi;  b = lo;
      end
      SEC_BLU_UP: begin
        r = lo;  g = hi;  b = mid;
      end
      SEC_BLU_FULL: begin
        r = lo;  g = mid; b = hi;
      end
      SEC_RED_RISE: begin
        r = mid; g = lo;  b = hi;
      end
      default: begin
        r = hi;  g = lo;  b = mid;
      end
    endcase
    out_pixel_nxt = {stg3.abyte, r, g, b};
  end

  always_ff @(posedge clk) begin
    out_pixel_r <= out_pixel_nxt;
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= stg3.valid;
    end
  end

  assign out_valid = out_valid_r;
  assign out_pixel = out_pixel_r;

endmodule

// ----- rtl/hsv_to_argb_colormap.sv -----
// HSV-to-ARGB pixel colorer with level colormap, four register stages.
// Path: an accepted start passes stg1, stg2, stg3 and the output register to out_valid.
// Throughput: one transaction per cycle; busy stays low, the pipeline never stalls.
// Stages: clamp and sector split, s*v multiply, chroma*weight multiply, byte pack.
// Reset (rst_n low, synchronous) clears all valid bits; no result is in flight after it.
// Depends on hsvc_pkg, hsvc_front, hsvc_mult, hsvc_pack and the macros header.
`include "hsv_to_argb_colormap_macros.svh"
module hsv_to_argb_colormap
  import hsvc_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  logic                 in_mode,
  input  logic [FRAC_BITS-1:0] in_hue,
  input  logic [QW-1:0]        in_saturation,
  input  logic [QW-1:0]        in_brightness,
  input  logic [QW-1:0]        in_alpha,
  input  logic [QW-1:0]        in_level,
  output logic                 out_valid,
  output logic [31:0]          out_pixel
);

  stg1_t stg1;
  stg3_t stg3;
  logic  accept;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  hsvc_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .accept        (accept),
    .in_mode       (in_mode),
    .in_hue        (in_hue),
    .in_saturation (in_saturation),
    .in_brightness (in_brightness),
    .in_alpha      (in_alpha),
    .in_level      (in_level),
    .stg1          (stg1)
  );

  hsvc_mult u_mult (
    .clk   (clk),
    .rst_n (rst_n),
    .stg1  (stg1),
    .stg3  (stg3)
  );

  hsvc_pack u_pack (
    .clk       (clk),
    .rst_n     (rst_n),
    .stg3      (stg3),
    .out_valid (out_valid),
    .out_pixel (out_pixel)
  );

  `HSVC_ASSERT_LAT4(a_latency, accept, out_valid, "accepted transaction lost in pipeline")
  `HSVC_ASSERT_LAT4(a_map_alpha, accept && in_mode, out_pixel[31:24] == 8'd0, "colormap alpha not zero")
  `HSVC_ASSERT_LAT4(a_map_top, accept && in_mode && (in_level >= ONE_Q), out_pixel == 32'd0, "colormap top not black")
  `HSVC_ASSERT_IMP(a_no_busy, start, !busy, "busy raised on a stall-free pipeline")

endmodule
